// ----- hw/rtl/dlfb_pkg.sv -----
// Shared types and codes of the fully connected layer engine.
// No dependencies; the datapath, sequencer, top level, checker and testbench refer to it by scoped names.
package dlfb_pkg;

  typedef enum logic [2:0] {
    ACT_LOAD_W = 3'd0,
    ACT_LOAD_B = 3'd1,
    ACT_FWD    = 3'd2,
    ACT_BWD    = 3'd3,
    ACT_RD_WG  = 3'd4,
    ACT_RD_BG  = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FWD = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_FWD_OUT = 2'd0,
    KIND_IN_GRAD = 2'd1,
    KIND_W_GRAD  = 2'd2,
    KIND_B_GRAD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_IN_USED  = 2'd0,
    CFG_OUT_USED = 2'd1,
    CFG_BIAS_EN  = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD_W,
    DP_LOAD_B,
    DP_CACHE_X,
    DP_FWD,
    DP_BWD,
    DP_BG_RD,
    DP_BG_WR,
    DP_EMIT_RD,
    DP_EMIT_OUT,
    DP_RD_G,
    DP_RD_OUT,
    DP_ERR_OUT,
    DP_CLR_ALL,
    DP_CLR_GRAD
  } dp_op_e;

  typedef struct packed {
    logic    in_ready;
    dp_op_e  op;
    status_e err;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    act_e       action;
    logic       k_bad;
    logic       c_bad;
    logic       r_bad;
    logic       row_end;
    logic       batch_start;
    logic       bias_en;
    logic       out_free;
    logic       pipe_busy;
    logic [6:0] nin;
    logic [6:0] nout;
  } sts_t;

endpackage

// ----- hw/rtl/dlfb_in_if.sv -----
// Input item channel of the layer engine: valid, ready and item fields.
// No dependencies.
interface dlfb_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [3:0]         row;
  logic [5:0]         feature_index;
  logic [5:0]         output_index;
  logic signed [31:0] value;
  logic               row_end;
  logic               batch_start;

  modport source (output valid, action, row, feature_index, output_index, value,
                  row_end, batch_start, input ready);
  modport sink (input valid, action, row, feature_index, output_index, value,
                row_end, batch_start, output ready);
endinterface

// ----- hw/rtl/dlfb_out_if.sv -----
// Result channel of the layer engine: valid, ready and result fields.
// No dependencies.
interface dlfb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [5:0]         result_index;
  logic [1:0]         result_kind;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, result_value, result_index, result_kind, status, last,
                  input ready);
  modport sink (input valid, result_value, result_index, result_kind, status, last,
                output ready);
endinterface

// ----- hw/rtl/dlfb_dp.sv -----
// Datapath of the layer engine: item and config registers, stores, MAC pipeline,
// result register. Depends on dlfb_pkg, dlfb_in_if and dlfb_out_if.
module dlfb_dp #(
  parameter int MAX_IN     = 64,
  parameter int MAX_OUT    = 64,
  parameter int MAX_ROWS   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  dlfb_in_if.sink             in_if,
  dlfb_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [6:0]          cfg_data_i,
  input  dlfb_pkg::cmd_t      cmd_i,
  input  logic [IW-1:0]       idx_i,
  output dlfb_pkg::sts_t      sts_o
);

  localparam int WD    = MAX_IN * MAX_OUT;
  localparam int XD    = MAX_ROWS * MAX_IN;
  localparam int KW    = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int OW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int AW    = (WD > 1) ? $clog2(WD) : 1;
  localparam int XW    = (XD > 1) ? $clog2(XD) : 1;
  localparam int RES_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic [6:0] CAP_IN  = 7'((MAX_IN < 64) ? MAX_IN : 64);
  localparam logic [6:0] CAP_OUT = 7'((MAX_OUT < 64) ? MAX_OUT : 64);
  localparam logic signed [48:0] RES_HI = (49'sd1 <<< (RES_W - 1)) - 49'sd1;
  localparam logic signed [48:0] RES_LO = -RES_HI - 49'sd1;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] s);
    logic signed [47:0] r;
    if (s[48] != s[47]) begin
      r = s[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    end else begin
      r = s[47:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] res_sat(input logic signed [48:0] s);
    logic signed [48:0] t;
    if (s > RES_HI) begin
      t = RES_HI;
    end else if (s < RES_LO) begin
      t = RES_LO;
    end else begin
      t = s;
    end
    return t[31:0];
  endfunction

  // item and configuration registers
  logic [2:0]         act_q;
  logic [3:0]         row_q;
  logic [5:0]         k_q, c_q;
  logic signed [31:0] v_q;
  logic               row_end_q, bs_q;
  logic [6:0]         in_used_q, out_used_q;
  logic               bias_en_q;
  logic               in_fire;

  assign in_if.ready = cmd_i.in_ready;
  assign in_fire     = in_if.valid & cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q     <= in_if.action;
      row_q     <= in_if.row;
      k_q       <= in_if.feature_index;
      c_q       <= in_if.output_index;
      v_q       <= in_if.value;
      row_end_q <= in_if.row_end;
      bs_q      <= in_if.batch_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_used_q  <= 7'd64;
      out_used_q <= 7'd64;
      bias_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (dlfb_pkg::cfg_e'(cfg_idx_i))
        dlfb_pkg::CFG_IN_USED:  in_used_q  <= cfg_data_i;
        dlfb_pkg::CFG_OUT_USED: out_used_q <= cfg_data_i;
        dlfb_pkg::CFG_BIAS_EN:  bias_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [6:0] nin, nout;
  assign nin  = (in_used_q == 7'd0) ? 7'd1 : (in_used_q > CAP_IN) ? CAP_IN : in_used_q;
  assign nout = (out_used_q == 7'd0) ? 7'd1 : (out_used_q > CAP_OUT) ? CAP_OUT : out_used_q;

  dlfb_pkg::dp_op_e op;
  logic             is_fwd;
  assign op     = cmd_i.op;
  assign is_fwd = (dlfb_pkg::act_e'(act_q) == dlfb_pkg::ACT_FWD);

  // addresses
  logic [AW-1:0] ld_waddr, fwd_waddr, bwd_waddr, clr_addr;
  logic [XW-1:0] x_waddr, x_raddr;
  logic [OW-1:0] o_idx, c_o;
  logic [KW-1:0] i_idx;

  assign ld_waddr  = AW'(32'(k_q) * MAX_OUT + 32'(c_q));
  assign fwd_waddr = AW'(32'(k_q) * MAX_OUT + 32'(idx_i));
  assign bwd_waddr = AW'(32'(idx_i) * MAX_OUT + 32'(c_q));
  assign clr_addr  = idx_i[AW-1:0];
  assign x_waddr   = XW'(32'(row_q) * MAX_IN + 32'(k_q));
  assign x_raddr   = XW'(32'(row_q) * MAX_IN + 32'(idx_i));
  assign o_idx     = idx_i[OW-1:0];
  assign i_idx     = idx_i[KW-1:0];
  assign c_o       = OW'(c_q);

  logic clr_any, clr_o_ok, clr_i_ok;
  assign clr_any  = (op == dlfb_pkg::DP_CLR_ALL) || (op == dlfb_pkg::DP_CLR_GRAD);
  assign clr_o_ok = 32'(idx_i) < MAX_OUT;
  assign clr_i_ok = 32'(idx_i) < MAX_IN;

  // pipeline registers
  logic               s1_vld_q, s1_fwd_q, s2_vld_q, s2_fwd_q;
  logic [IW-1:0]      s1_idx_q, s2_idx_q;
  logic [AW-1:0]      s1_waddr_q, s2_waddr_q;
  logic signed [63:0] p_a_d, p_b_d, p_a_q, p_b_q;
  logic signed [47:0] acc_q, wgv_q, ta, tb, sum_a, sum_b;

  // stores
  logic signed [31:0] w_mem  [WD];
  logic signed [31:0] b_mem  [MAX_OUT];
  logic signed [31:0] x_mem  [XD];
  logic signed [47:0] fa_mem [MAX_OUT];
  logic signed [47:0] ig_mem [MAX_IN];
  logic signed [47:0] wg_mem [WD];
  logic signed [47:0] bg_mem [MAX_OUT];
  logic signed [31:0] w_rd_q, b_rd_q, x_rd_q;
  logic signed [47:0] fa_rd_q, ig_rd_q, wg_rd_q, bg_rd_q;

  always_ff @(posedge clk_i) begin
    if (op == dlfb_pkg::DP_LOAD_W) w_mem[ld_waddr] <= v_q;
    if (op == dlfb_pkg::DP_FWD) w_rd_q <= w_mem[fwd_waddr];
    else if (op == dlfb_pkg::DP_BWD) w_rd_q <= w_mem[bwd_waddr];
  end

  always_ff @(posedge clk_i) begin
    if (op == dlfb_pkg::DP_LOAD_B) b_mem[c_o] <= v_q;
    if (op == dlfb_pkg::DP_EMIT_RD) b_rd_q <= b_mem[o_idx];
  end

  always_ff @(posedge clk_i) begin
    if (op == dlfb_pkg::DP_CACHE_X) x_mem[x_waddr] <= v_q;
    if (op == dlfb_pkg::DP_BWD) x_rd_q <= x_mem[x_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && s2_fwd_q) begin
      fa_mem[s2_idx_q[OW-1:0]] <= sum_a;
    end else if ((op == dlfb_pkg::DP_EMIT_OUT && is_fwd) ||
                 (op == dlfb_pkg::DP_CLR_ALL && clr_o_ok)) begin
      fa_mem[o_idx] <= '0;
    end
    if (op == dlfb_pkg::DP_FWD || (op == dlfb_pkg::DP_EMIT_RD && is_fwd)) begin
      fa_rd_q <= fa_mem[o_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && !s2_fwd_q) begin
      ig_mem[s2_idx_q[KW-1:0]] <= sum_a;
    end else if ((op == dlfb_pkg::DP_EMIT_OUT && !is_fwd) ||
                 (op == dlfb_pkg::DP_CLR_ALL && clr_i_ok)) begin
      ig_mem[i_idx] <= '0;
    end
    if (op == dlfb_pkg::DP_BWD || (op == dlfb_pkg::DP_EMIT_RD && !is_fwd)) begin
      ig_rd_q <= ig_mem[i_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && !s2_fwd_q) begin
      wg_mem[s2_waddr_q] <= sum_b;
    end else if (clr_any) begin
      wg_mem[clr_addr] <= '0;
    end
    if (op == dlfb_pkg::DP_BWD) wg_rd_q <= wg_mem[bwd_waddr];
    else if (op == dlfb_pkg::DP_RD_G) wg_rd_q <= wg_mem[ld_waddr];
  end

  always_ff @(posedge clk_i) begin
    if (op == dlfb_pkg::DP_BG_WR) begin
      bg_mem[c_o] <= sat48(49'(bg_rd_q) + 49'(v_q));
    end else if (clr_any && clr_o_ok) begin
      bg_mem[o_idx] <= '0;
    end
    if (op == dlfb_pkg::DP_BG_RD || op == dlfb_pkg::DP_RD_G) bg_rd_q <= bg_mem[c_o];
  end

  // multiply-accumulate pipeline: issue, multiply, add and write back
  assign p_a_d = v_q * w_rd_q;
  assign p_b_d = x_rd_q * v_q;
  assign ta    = p_a_q[63:16];
  assign tb    = p_b_q[63:16];
  assign sum_a = sat48(49'(acc_q) + 49'(ta));
  assign sum_b = sat48(49'(wgv_q) + 49'(tb));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= (op == dlfb_pkg::DP_FWD) || (op == dlfb_pkg::DP_BWD);
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_fwd_q   <= (op == dlfb_pkg::DP_FWD);
    s1_idx_q   <= idx_i;
    s1_waddr_q <= bwd_waddr;
    s2_fwd_q   <= s1_fwd_q;
    s2_idx_q   <= s1_idx_q;
    s2_waddr_q <= s1_waddr_q;
    p_a_q      <= p_a_d;
    p_b_q      <= p_b_d;
    acc_q      <= s1_fwd_q ? fa_rd_q : ig_rd_q;
    wgv_q      <= wg_rd_q;
  end

  // result register
  logic               out_vld_q;
  logic [31:0]        res_val_q;
  logic [5:0]         res_idx_q;
  logic [1:0]         res_kind_q, res_st_q;
  logic               res_last_q;
  logic signed [48:0] bias_ext, em_sum;
  logic               out_load;

  assign bias_ext = bias_en_q ? 49'(b_rd_q) : 49'sd0;
  assign em_sum   = is_fwd ? (49'(fa_rd_q) + bias_ext) : 49'(ig_rd_q);
  assign out_load = (op == dlfb_pkg::DP_EMIT_OUT) || (op == dlfb_pkg::DP_RD_OUT) ||
                    (op == dlfb_pkg::DP_ERR_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      dlfb_pkg::DP_EMIT_OUT: begin
        res_val_q  <= res_sat(em_sum);
        res_idx_q  <= 6'(idx_i);
        res_kind_q <= is_fwd ? dlfb_pkg::KIND_FWD_OUT : dlfb_pkg::KIND_IN_GRAD;
        res_st_q   <= dlfb_pkg::ST_OK;
        res_last_q <= cmd_i.last;
      end
      dlfb_pkg::DP_RD_OUT: begin
        if (dlfb_pkg::act_e'(act_q) == dlfb_pkg::ACT_RD_WG) begin
          res_val_q  <= res_sat(49'(wg_rd_q));
          res_idx_q  <= k_q;
          res_kind_q <= dlfb_pkg::KIND_W_GRAD;
        end else begin
          res_val_q  <= res_sat(49'(bg_rd_q));
          res_idx_q  <= c_q;
          res_kind_q <= dlfb_pkg::KIND_B_GRAD;
        end
        res_st_q   <= dlfb_pkg::ST_OK;
        res_last_q <= 1'b1;
      end
      dlfb_pkg::DP_ERR_OUT: begin
        res_val_q  <= '0;
        res_idx_q  <= '0;
        res_kind_q <= dlfb_pkg::KIND_FWD_OUT;
        res_st_q   <= cmd_i.err;
        res_last_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_if.valid        = out_vld_q;
  assign out_if.result_value = res_val_q;
  assign out_if.result_index = res_idx_q;
  assign out_if.result_kind  = res_kind_q;
  assign out_if.status       = res_st_q;
  assign out_if.last         = res_last_q;

  always_comb begin
    sts_o.in_valid    = in_if.valid;
    sts_o.action      = dlfb_pkg::act_e'(act_q);
    sts_o.k_bad       = {1'b0, k_q} >= nin;
    sts_o.c_bad       = {1'b0, c_q} >= nout;
    sts_o.r_bad       = 32'(row_q) >= MAX_ROWS;
    sts_o.row_end     = row_end_q;
    sts_o.batch_start = bs_q;
    sts_o.bias_en     = bias_en_q;
    sts_o.out_free    = !out_vld_q || out_if.ready;
    sts_o.pipe_busy   = s1_vld_q || s2_vld_q;
    sts_o.nin         = nin;
    sts_o.nout        = nout;
  end

endmodule

// ----- hw/rtl/dlfb_ctrl.sv -----
// Sequencer of the layer engine: decodes items, runs element loops and sweeps.
// Depends on dlfb_pkg; drives dlfb_dp through command and status structs.
module dlfb_ctrl #(
  parameter int IW       = 12,
  parameter int WG_DEPTH = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dlfb_pkg::sts_t sts_i,
  output dlfb_pkg::cmd_t cmd_o,
  output logic [IW-1:0]  idx_o
);

  typedef enum logic [10:0] {
    S_CLR      = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_DEC      = 11'b000_0000_0100,
    S_ERR      = 11'b000_0000_1000,
    S_RD_OUT   = 11'b000_0001_0000,
    S_FWD      = 11'b000_0010_0000,
    S_BWD      = 11'b000_0100_0000,
    S_DRAIN    = 11'b000_1000_0000,
    S_BG_WR    = 11'b001_0000_0000,
    S_EMIT_RD  = 11'b010_0000_0000,
    S_EMIT_OUT = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              clr_all_q, clr_all_d;
  logic              cache_vld_q, cache_vld_d;
  logic              bwd_open_q, bwd_open_d;
  dlfb_pkg::status_e err_q, err_d;
  logic              fwd_end, bwd_end, emit_end, clr_end, is_fwd;

  assign is_fwd   = (sts_i.action == dlfb_pkg::ACT_FWD);
  assign fwd_end  = 32'(idx_q) == 32'(sts_i.nout) - 32'd1;
  assign bwd_end  = 32'(idx_q) == 32'(sts_i.nin) - 32'd1;
  assign emit_end = is_fwd ? fwd_end : bwd_end;
  assign clr_end  = 32'(idx_q) == WG_DEPTH - 1;
  assign idx_o    = idx_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    clr_all_d   = clr_all_q;
    cache_vld_d = cache_vld_q;
    bwd_open_d  = bwd_open_q;
    err_d       = err_q;
    cmd_o.in_ready = 1'b0;
    cmd_o.op       = dlfb_pkg::DP_NONE;
    cmd_o.err      = err_q;
    cmd_o.last     = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.op = clr_all_q ? dlfb_pkg::DP_CLR_ALL : dlfb_pkg::DP_CLR_GRAD;
        if (clr_end) begin
          idx_d   = '0;
          state_d = clr_all_q ? S_IDLE : S_BWD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) state_d = S_DEC;
      end
      S_DEC: begin
        idx_d   = '0;
        state_d = S_IDLE;
        case (sts_i.action)
          dlfb_pkg::ACT_LOAD_W: begin
            if (sts_i.k_bad || sts_i.c_bad) begin
              err_d   = dlfb_pkg::ST_RANGE;
              state_d = S_ERR;
            end else begin
              cmd_o.op = dlfb_pkg::DP_LOAD_W;
            end
          end
          dlfb_pkg::ACT_LOAD_B: begin
            if (sts_i.c_bad) begin
              err_d   = dlfb_pkg::ST_RANGE;
              state_d = S_ERR;
            end else begin
              cmd_o.op = dlfb_pkg::DP_LOAD_B;
            end
          end
          dlfb_pkg::ACT_FWD: begin
            if (sts_i.k_bad || sts_i.r_bad) begin
              err_d   = dlfb_pkg::ST_RANGE;
              state_d = S_ERR;
            end else begin
              cmd_o.op = dlfb_pkg::DP_CACHE_X;
              state_d  = S_FWD;
            end
          end
          dlfb_pkg::ACT_BWD: begin
            if (!cache_vld_q) begin
              err_d   = dlfb_pkg::ST_NO_FWD;
              state_d = S_ERR;
            end else if (sts_i.c_bad || sts_i.r_bad) begin
              err_d   = dlfb_pkg::ST_RANGE;
              state_d = S_ERR;
            end else begin
              bwd_open_d = 1'b1;
              if (sts_i.batch_start && !bwd_open_q) begin
                clr_all_d = 1'b0;
                state_d   = S_CLR;
              end else begin
                state_d = S_BWD;
              end
            end
          end
          dlfb_pkg::ACT_RD_WG: begin
            if (sts_i.k_bad || sts_i.c_bad) begin
              err_d   = dlfb_pkg::ST_RANGE;
              state_d = S_ERR;
            end else begin
              cmd_o.op = dlfb_pkg::DP_RD_G;
              state_d  = S_RD_OUT;
            end
          end
          dlfb_pkg::ACT_RD_BG: begin
            if (sts_i.c_bad) begin
              err_d   = dlfb_pkg::ST_RANGE;
              state_d = S_ERR;
            end else begin
              cmd_o.op = dlfb_pkg::DP_RD_G;
              state_d  = S_RD_OUT;
            end
          end
          default: ;
        endcase
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.op   = dlfb_pkg::DP_ERR_OUT;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op   = dlfb_pkg::DP_RD_OUT;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_FWD: begin
        cmd_o.op = dlfb_pkg::DP_FWD;
        if (fwd_end) state_d = S_DRAIN;
        else idx_d = idx_q + 1'b1;
      end
      S_BWD: begin
        cmd_o.op = dlfb_pkg::DP_BWD;
        if (bwd_end) state_d = S_DRAIN;
        else idx_d = idx_q + 1'b1;
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          idx_d = '0;
          if (!is_fwd && sts_i.bias_en) begin
            cmd_o.op = dlfb_pkg::DP_BG_RD;
            state_d  = S_BG_WR;
          end else if (sts_i.row_end) begin
            state_d = S_EMIT_RD;
            if (is_fwd) cache_vld_d = 1'b1;
            else bwd_open_d = 1'b0;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_BG_WR: begin
        cmd_o.op = dlfb_pkg::DP_BG_WR;
        if (sts_i.row_end) begin
          bwd_open_d = 1'b0;
          state_d    = S_EMIT_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd_o.op = dlfb_pkg::DP_EMIT_RD;
        state_d  = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op   = dlfb_pkg::DP_EMIT_OUT;
          cmd_o.last = emit_end;
          if (emit_end) begin
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      idx_q       <= '0;
      clr_all_q   <= 1'b1;
      cache_vld_q <= 1'b0;
      bwd_open_q  <= 1'b0;
      err_q       <= dlfb_pkg::ST_OK;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      clr_all_q   <= clr_all_d;
      cache_vld_q <= cache_vld_d;
      bwd_open_q  <= bwd_open_d;
      err_q       <= err_d;
    end
  end

endmodule

// ----- hw/rtl/dense_layer_forward_backward.sv -----
// Fully connected layer engine, forward and backward, signed Q16.16.
// A forward item runs over the n outputs in use, a backward item over the n inputs in use,
// one element per cycle through the shared multiply-accumulate pipeline; a backward item
// with bias adds a bias gradient update, and row_end adds a read and an emit per result.
// Batch clear sweeps all MAX_IN*MAX_OUT gradient store entries, one entry per cycle.
// After reset a sweep of all MAX_IN*MAX_OUT entries zeroes accumulators and gradients.
module dense_layer_forward_backward #(
  parameter int MAX_IN     = 64,
  parameter int MAX_OUT    = 64,
  parameter int MAX_ROWS   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlfb_in_if.sink    in_i,
  dlfb_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  localparam int WG_DEPTH = MAX_IN * MAX_OUT;
  localparam int IW       = (WG_DEPTH > 1) ? $clog2(WG_DEPTH) : 1;

  dlfb_pkg::cmd_t cmd;
  dlfb_pkg::sts_t sts;
  logic [IW-1:0]  idx;

  dlfb_ctrl #(
    .IW       (IW),
    .WG_DEPTH (WG_DEPTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .idx_o  (idx)
  );

  dlfb_dp #(
    .MAX_IN     (MAX_IN),
    .MAX_OUT    (MAX_OUT),
    .MAX_ROWS   (MAX_ROWS),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_i),
    .out_if     (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .sts_o      (sts)
  );

endmodule

// ----- hw/rtl/dlfb_chk.sv -----
// Port-level checks of the layer engine result channel, bound to the top level.
// Depends on dlfb_pkg and dense_layer_forward_backward.
module dlfb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] result_value_i,
  input logic [5:0]  result_index_i,
  input logic [1:0]  result_kind_i,
  input logic [1:0]  status_i,
  input logic        last_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(result_value_i) && $stable(result_index_i)
      && $stable(result_kind_i) && $stable(status_i) && $stable(last_i))
    else $error("stalled result changed");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != dlfb_pkg::ST_OK |-> result_value_i == 32'd0 &&
      result_index_i == 6'd0 && result_kind_i == dlfb_pkg::KIND_FWD_OUT && last_i)
    else $error("malformed error result");

  a_read_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == dlfb_pkg::KIND_W_GRAD ||
      result_kind_i == dlfb_pkg::KIND_B_GRAD) |-> last_i && status_i == dlfb_pkg::ST_OK)
    else $error("gradient read not a single ok result");

endmodule

bind dense_layer_forward_backward dlfb_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_value_i (out_o.result_value),
  .result_index_i (out_o.result_index),
  .result_kind_i  (out_o.result_kind),
  .status_i       (out_o.status),
  .last_i         (out_o.last)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the fully connected layer engine.
// Depends on dlfb_pkg, dlfb_in_if, dlfb_out_if and dense_layer_forward_backward;
// a Q16.16 layer predictor checks every result transfer in order.
module tb_top;

  typedef struct {
    logic [31:0] value;
    logic [5:0]  index;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        last;
  } layer_res_t;

  typedef struct {
    logic [2:0]  act;
    logic [3:0]  row;
    logic [5:0]  k;
    logic [5:0]  c;
    logic [31:0] v;
    logic        re;
    logic        bs;
    bit          typed;
    layer_res_t  res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [6:0] cfg_data_i;

  dlfb_in_if  inb ();
  dlfb_out_if outb ();

  dense_layer_forward_backward uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (inb),
    .out_o      (outb),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  longint weight_q[4096];
  longint bias_q[64];
  longint fwd_acc[64];
  longint x_cache[1024];
  longint in_grad_acc[64];
  longint w_grad[4096];
  longint b_grad[64];
  bit     cache_ok;
  bit     grad_row_open;
  logic [6:0] in_used_reg;
  logic [6:0] out_used_reg;
  logic       bias_on;

  layer_res_t expected_q[$];
  layer_res_t fresh_q[$];

  int idle_pct;
  int stall_pct;
  int hold_cycles;
  bit hold_go = 1'b0;
  int mismatches = 0;
  int items_sent;
  int results_seen = 0;
  int clears_seen;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint sat_to(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic int clamp_used(logic [6:0] r);
    if (r < 1) return 1;
    if (r > 64) return 64;
    return int'(r);
  endfunction

  function automatic layer_res_t mk_res(longint v, int idx, dlfb_pkg::kind_e kd,
                                        dlfb_pkg::status_e st, bit lst);
    layer_res_t t;
    t.value  = 32'(sat_to(v, 32));
    t.index  = 6'(idx);
    t.kind   = kd;
    t.status = st;
    t.last   = lst;
    return t;
  endfunction

  task automatic layer_step(logic [2:0] act, logic [3:0] r, logic [5:0] k, logic [5:0] c,
                            logic [31:0] v, logic re, logic bs);
    int nin;
    int nout;
    longint x;
    longint s;
    nin  = clamp_used(in_used_reg);
    nout = clamp_used(out_used_reg);
    x    = longint'($signed(v));
    fresh_q.delete();
    case (act)
      dlfb_pkg::ACT_LOAD_W: begin
        if (k >= nin || c >= nout)
          fresh_q.push_back(mk_res(0, 0, dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE, 1));
        else weight_q[k * 64 + c] = x;
      end
      dlfb_pkg::ACT_LOAD_B: begin
        if (c >= nout)
          fresh_q.push_back(mk_res(0, 0, dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE, 1));
        else bias_q[c] = x;
      end
      dlfb_pkg::ACT_FWD: begin
        if (k >= nin) begin
          fresh_q.push_back(mk_res(0, 0, dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE, 1));
        end else begin
          x_cache[r * 64 + k] = x;
          for (int i = 0; i < nout; i++)
            fwd_acc[i] = sat_to(fwd_acc[i] + q_mul(x, weight_q[k * 64 + i]), 48);
          if (re) begin
            for (int i = 0; i < nout; i++) begin
              s = fwd_acc[i] + (bias_on ? bias_q[i] : 0);
              fresh_q.push_back(mk_res(s, i, dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_OK,
                                       i + 1 == nout));
              fwd_acc[i] = 0;
            end
            cache_ok = 1;
          end
        end
      end
      dlfb_pkg::ACT_BWD: begin
        if (!cache_ok) begin
          fresh_q.push_back(mk_res(0, 0, dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_NO_FWD, 1));
        end else if (c >= nout) begin
          fresh_q.push_back(mk_res(0, 0, dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE, 1));
        end else begin
          if (bs && !grad_row_open) begin
            foreach (w_grad[i]) w_grad[i] = 0;
            foreach (b_grad[i]) b_grad[i] = 0;
            clears_seen++;
          end
          grad_row_open = 1;
          for (int i = 0; i < nin; i++) begin
            in_grad_acc[i] = sat_to(in_grad_acc[i] + q_mul(x, weight_q[i * 64 + c]), 48);
            w_grad[i * 64 + c] = sat_to(w_grad[i * 64 + c] + q_mul(x_cache[r * 64 + i], x),
                                        48);
          end
          if (bias_on) b_grad[c] = sat_to(b_grad[c] + x, 48);
          if (re) begin
            for (int i = 0; i < nin; i++) begin
              fresh_q.push_back(mk_res(in_grad_acc[i], i, dlfb_pkg::KIND_IN_GRAD,
                                       dlfb_pkg::ST_OK, i + 1 == nin));
              in_grad_acc[i] = 0;
            end
            grad_row_open = 0;
          end
        end
      end
      dlfb_pkg::ACT_RD_WG: begin
        if (k >= nin || c >= nout)
          fresh_q.push_back(mk_res(0, 0, dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE, 1));
        else fresh_q.push_back(mk_res(w_grad[k * 64 + c], k, dlfb_pkg::KIND_W_GRAD,
                                      dlfb_pkg::ST_OK, 1));
      end
      dlfb_pkg::ACT_RD_BG: begin
        if (c >= nout)
          fresh_q.push_back(mk_res(0, 0, dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE, 1));
        else fresh_q.push_back(mk_res(b_grad[c], c, dlfb_pkg::KIND_B_GRAD,
                                      dlfb_pkg::ST_OK, 1));
      end
      default: ;
    endcase
  endtask

  task automatic send_item(stim_row_t s);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      inb.valid = 1'b0;
      @(negedge clk_i);
    end
    inb.valid         = 1'b1;
    inb.action        = s.act;
    inb.row           = s.row;
    inb.feature_index = s.k;
    inb.output_index  = s.c;
    inb.value         = s.v;
    inb.row_end       = s.re;
    inb.batch_start   = s.bs;
    do @(posedge clk_i); while (!inb.ready);
    layer_step(s.act, s.row, s.k, s.c, s.v, s.re, s.bs);
    if (s.act <= 3'd5) items_sent++;
    if (s.typed) expected_q.push_back(s.res);
    else foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
  endtask

  function automatic stim_row_t mk_item(logic [2:0] act, int r, int k, int c, logic [31:0] v,
                                        bit re, bit bs);
    stim_row_t s;
    s.act   = act;
    s.row   = 4'(r);
    s.k     = 6'(k);
    s.c     = 6'(c);
    s.v     = v;
    s.re    = re;
    s.bs    = bs;
    s.typed = 0;
    s.res   = mk_res(0, 0, dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_OK, 1);
    return s;
  endfunction

  function automatic stim_row_t mk_typed(stim_row_t s, longint v, int idx, dlfb_pkg::kind_e kd,
                                         dlfb_pkg::status_e st);
    s.typed = 1;
    s.res   = mk_res(v, idx, kd, st, 1);
    return s;
  endfunction

  task automatic drain;
    @(negedge clk_i);
    inb.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4500) @(negedge clk_i);
  endtask

  task automatic cfg_write(dlfb_pkg::cfg_e idx, logic [6:0] data);
    drain();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      dlfb_pkg::CFG_IN_USED:  in_used_reg  = data;
      dlfb_pkg::CFG_OUT_USED: out_used_reg = data;
      default:                bias_on      = data[0];
    endcase
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3, 4:    return $signed($urandom) >>> $urandom_range(8, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic layer_sequence();
    int nin;
    int nout;
    int r;
    nin  = clamp_used(in_used_reg);
    nout = clamp_used(out_used_reg);
    r    = $urandom_range(15);
    for (int k = 0; k < nin; k++)
      send_item(mk_item(dlfb_pkg::ACT_FWD, r, k, $urandom_range(63), rand_value(),
                        k == nin - 1, 1'($urandom_range(1))));
    for (int c = 0; c < nout; c++)
      send_item(mk_item(dlfb_pkg::ACT_BWD, r, $urandom_range(63), $urandom_range(nout - 1),
                        rand_value(), c == nout - 1, c == 0 && $urandom_range(4) == 0));
    repeat ($urandom_range(2))
      send_item(mk_item(dlfb_pkg::ACT_RD_WG, 0, $urandom_range(nin - 1),
                        $urandom_range(nout - 1), 0, 0, 0));
    send_item(mk_item(dlfb_pkg::ACT_RD_BG, 0, 0, $urandom_range(nout - 1), 0, 0, 0));
  endtask

  initial begin
    hold_cycles = 0;
    wait (hold_go);
    hold_cycles = 3000;
    while (hold_cycles > 0) begin
      @(negedge clk_i);
      hold_cycles--;
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      outb.ready <= 1'b0;
    end else begin
      outb.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    layer_res_t e;
    if (rst_ni && outb.valid && outb.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: value %h index %0d",
                                       outb.result_value, outb.result_index);
      end else begin
        e = expected_q.pop_front();
        if (outb.result_value !== e.value || outb.result_index !== e.index ||
            outb.result_kind !== e.kind || outb.status !== e.status || outb.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp val %h idx %0d kind %0d st %0d last %0d, %s %h %0d %0d %0d %0d",
                     e.value, e.index, e.kind, e.status, e.last, "got", outb.result_value,
                     outb.result_index, outb.result_kind, outb.status, outb.last);
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    stim_row_t dir_q[$];
    int nin;
    int nout;
    int target;
    int pick;
    logic [6:0] in_set[6]  = '{7'd1, 7'd4, 7'd0, 7'd2, 7'd8, 7'd127};
    logic [6:0] out_set[6] = '{7'd1, 7'd3, 7'd127, 7'd4, 7'd2, 7'd0};
    logic       bias_set[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    int idle_set[4]  = '{0, 56, 0, 24};
    int stall_set[4] = '{0, 0, 56, 24};

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = dlfb_pkg::CFG_IN_USED;
    cfg_data_i  = '0;
    inb.valid   = 1'b0;
    inb.action  = dlfb_pkg::ACT_LOAD_W;
    inb.row     = '0;
    inb.feature_index = '0;
    inb.output_index  = '0;
    inb.value   = '0;
    inb.row_end = 1'b0;
    inb.batch_start = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    clears_seen = 0;
    foreach (fwd_acc[i]) begin
      fwd_acc[i] = 0;
      in_grad_acc[i] = 0;
      b_grad[i] = 0;
    end
    foreach (w_grad[i]) w_grad[i] = 0;
    cache_ok = 0;
    grad_row_open = 0;
    in_used_reg = 7'd64;
    out_used_reg = 7'd64;
    bias_on = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset state: no forward yet, gradients zero
    dir_q.push_back(mk_typed(mk_item(dlfb_pkg::ACT_BWD, 0, 0, 5, 32'h0001_0000, 1, 1), 0, 0,
                             dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_NO_FWD));
    dir_q.push_back(mk_typed(mk_item(dlfb_pkg::ACT_RD_WG, 0, 0, 0, 0, 0, 0), 0, 0,
                             dlfb_pkg::KIND_W_GRAD, dlfb_pkg::ST_OK));
    dir_q.push_back(mk_typed(mk_item(dlfb_pkg::ACT_RD_BG, 0, 0, 63, 0, 0, 0), 0, 63,
                             dlfb_pkg::KIND_B_GRAD, dlfb_pkg::ST_OK));
    dir_q.push_back(mk_item(3'd6, 3, 7, 9, 32'hdead_beef, 1, 1));
    foreach (dir_q[i]) send_item(dir_q[i]);
    dir_q.delete();

    // fill the weights, biases and row 0 inputs that the chosen shapes reach
    for (int k = 0; k < 64; k++)
      for (int c = 0; c < 64; c++)
        if (k == 0 || c == 0 || (k < 8 && c < 4))
          send_item(mk_item(dlfb_pkg::ACT_LOAD_W, 0, k, c, rand_value(), 0, 0));
    for (int c = 0; c < 4; c++)
      send_item(mk_item(dlfb_pkg::ACT_LOAD_B, 0, 0, c, rand_value(), 0, 0));
    cfg_write(dlfb_pkg::CFG_OUT_USED, 7'd1);
    for (int k = 0; k < 64; k++)
      send_item(mk_item(dlfb_pkg::ACT_FWD, 0, k, 0, rand_value(), k == 63, 0));

    cfg_write(dlfb_pkg::CFG_IN_USED, 7'd4);
    cfg_write(dlfb_pkg::CFG_OUT_USED, 7'd3);
    dir_q.push_back(mk_typed(mk_item(dlfb_pkg::ACT_LOAD_W, 0, 4, 0, 1, 0, 0), 0, 0,
                             dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE));
    dir_q.push_back(mk_typed(mk_item(dlfb_pkg::ACT_LOAD_B, 0, 0, 3, 1, 0, 0), 0, 0,
                             dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE));
    dir_q.push_back(mk_typed(mk_item(dlfb_pkg::ACT_RD_WG, 0, 1, 63, 0, 0, 0), 0, 0,
                             dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE));
    dir_q.push_back(mk_typed(mk_item(dlfb_pkg::ACT_RD_BG, 0, 0, 3, 0, 0, 0), 0, 0,
                             dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE));
    dir_q.push_back(mk_typed(mk_item(dlfb_pkg::ACT_FWD, 15, 63, 0, 5, 1, 0), 0, 0,
                             dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_LOAD_W, 0, 0, 0, 32'h7fff_ffff, 0, 0));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_LOAD_W, 0, 1, 0, 32'h8000_0000, 0, 0));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_LOAD_B, 0, 0, 2, 32'h8000_0000, 0, 0));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_FWD, 15, 0, 0, 32'h7fff_ffff, 0, 0));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_FWD, 15, 1, 0, 32'h8000_0000, 0, 0));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_FWD, 15, 2, 0, 32'hffff_ffff, 0, 0));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_FWD, 15, 3, 0, 32'h0001_0000, 1, 0));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_BWD, 15, 0, 0, 32'h7fff_ffff, 0, 1));
    dir_q.push_back(mk_typed(mk_item(dlfb_pkg::ACT_BWD, 15, 0, 3, 32'h1, 1, 0), 0, 0,
                             dlfb_pkg::KIND_FWD_OUT, dlfb_pkg::ST_RANGE));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_BWD, 15, 0, 1, 32'h8000_0000, 0, 1));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_BWD, 15, 0, 2, 32'h7fff_ffff, 1, 0));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_RD_WG, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_item(dlfb_pkg::ACT_RD_BG, 0, 0, 1, 0, 0, 0));
    dir_q.push_back(mk_item(3'd7, 2, 3, 1, 32'h1234_5678, 1, 0));
    foreach (dir_q[i]) send_item(dir_q[i]);

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(dlfb_pkg::CFG_IN_USED, in_set[ph]);
      cfg_write(dlfb_pkg::CFG_OUT_USED, out_set[ph]);
      cfg_write(dlfb_pkg::CFG_BIAS_EN, {6'd0, bias_set[ph]});
      idle_pct  = idle_set[ph % 4];
      stall_pct = stall_set[ph % 4];
      nin  = clamp_used(in_used_reg);
      nout = clamp_used(out_used_reg);
      if (ph == 1) hold_go = 1'b1;
      target = items_sent + 40;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          layer_sequence();
        end else if (pick < 70) begin
          send_item(mk_item(3'($urandom_range(1)), 0, $urandom_range(nin),
                            $urandom_range(nout), rand_value(), 1'($urandom_range(1)),
                            1'($urandom_range(1))));
        end else if (pick < 85) begin
          send_item(mk_item(3'(4 + $urandom_range(1)), $urandom_range(15), $urandom_range(63),
                            $urandom_range(63), $urandom, 1'($urandom_range(1)),
                            1'($urandom_range(1))));
        end else begin
          send_item(mk_item(3'($urandom_range(7)), 0, $urandom_range(63),
                            $urandom_range(63), rand_value(), 1'($urandom_range(1)),
                            1'($urandom_range(1))));
        end
      end
    end

    drain();
    $display("run covered %0d items and %0d results over 6 settings, %0d gradient clears",
             items_sent, results_seen, clears_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/dlfb_pkg.sv
hw/rtl/dlfb_in_if.sv
hw/rtl/dlfb_out_if.sv
hw/rtl/dlfb_dp.sv
hw/rtl/dlfb_ctrl.sv
hw/rtl/dense_layer_forward_backward.sv
hw/rtl/dlfb_chk.sv
tb/sv/tb_top.sv
